@@ rtl/hmeg_pkg.sv @@
// hmeg_pkg: shared constants, register codes and controller/datapath handshake types
`timescale 1ns / 1ps

package hmeg_pkg;

    // field widths
    localparam int IDX_W     = 10;
    localparam int ORD_W     = 11;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;

    // largest order the block accepts by default
    localparam int MAX_ORDER_DEF = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ORDER      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CONSTRUCTION_MODE = 1'b1;

    // register reset values
    localparam logic [ORD_W-1:0]  ORDER_RESET = 11'd4;

    // construction modes
    localparam logic [MODE_W-1:0] MODE_SYLVESTER = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PALEY1    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PALEY2    = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_SYLVESTER;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic prep;
        logic classify;
        logic mul_start;
        logic mul_step;
        logic out_load;
    } hmeg_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_euler;
        logic exp_zero;
        logic cnt_zero;
    } hmeg_status_t;

endpackage

@@ rtl/hmeg_ctrl.sv @@
// hmeg_ctrl: sequencing state machine and result word handshake
`timescale 1ns / 1ps

module hmeg_ctrl
    import hmeg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  logic         out_stall,
    input  hmeg_status_t status,
    output hmeg_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_CLASS = 6'b000100,
        S_CHECK = 6'b001000,
        S_MUL   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_CLASS;
            end
            S_CLASS:
            begin
                cmd.classify = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.need_euler && !status.exp_zero)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb
    begin
        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ rtl/hmeg_dp.sv @@
// hmeg_dp: configuration registers, entry classification and bit-serial modular exponentiation
`timescale 1ns / 1ps

module hmeg_dp
    import hmeg_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORD_W-1:0]     cfg_data,
    input  logic [IDX_W-1:0]     row_index,
    input  logic [IDX_W-1:0]     col_index,
    input  hmeg_cmd_t            cmd,
    output hmeg_status_t         status,
    output logic                 entry_negative,
    output logic                 invalid
);

    // modulus width and bit counter width
    localparam int QW = $clog2(MAX_ORDER);
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;
    localparam logic [CW-1:0] CNT_TOP = CW'(QW - 1);

    // configuration
    logic [ORD_W-1:0]  order_reg;
    logic [MODE_W-1:0] mode_reg;

    // captured request
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] col_reg;

    // prepared operands
    logic             ok_reg;
    logic [QW-1:0]    q_reg;
    logic [IDX_W-1:0] rr_reg;
    logic [IDX_W-1:0] cc_reg;
    logic             rb_reg;
    logic             cb_reg;
    logic             syl_neg_reg;
    logic             syl_mode_reg;
    logic             pal2_mode_reg;

    // classification and exponentiation state
    logic             direct_neg_reg;
    logic             inv_reg;
    logic             euler_reg;
    logic [QW-1:0]    exp_reg;
    logic [QW-1:0]    res_reg;
    logic [QW-1:0]    base_reg;
    logic [QW-1:0]    acc_r_reg;
    logic [QW-1:0]    acc_b_reg;
    logic [CW-1:0]    cnt_reg;

    // result word
    logic entry_negative_reg;
    logic invalid_reg;

    // prep logic signals
    logic [ORD_W-1:0] q1;
    logic [IDX_W-1:0] half;
    logic [IDX_W-1:0] q2;
    logic             n_ok;
    logic             ord_ok;
    logic             rb;
    logic             cb;
    logic [IDX_W-1:0] rr;
    logic [IDX_W-1:0] cc;

    // classify logic signals
    logic             eq;
    logic             rz;
    logic             cz;
    logic             direct_neg;
    logic             inv;
    logic             euler;
    logic [QW:0]      diff;
    logic [QW-1:0]    a_mod;

    // multiplier step results
    logic [QW-1:0]    acc_r_next;
    logic [QW-1:0]    acc_b_next;
    logic             nonres;

    // one step of interleaved multiply and reduce: 2*acc + bit*y, mod q
    function automatic logic [QW-1:0] mm_step(
        input logic [QW-1:0] acc,
        input logic          bitv,
        input logic [QW-1:0] y,
        input logic [QW-1:0] q
    );
        logic [QW:0] t;
        t = {acc, 1'b0};
        if (t >= {1'b0, q})
            t = t - {1'b0, q};
        if (bitv)
            t = t + {1'b0, y};
        if (t >= {1'b0, q})
            t = t - {1'b0, q};
        return t[QW-1:0];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            mode_reg  <= MODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MATRIX_ORDER:      order_reg <= cfg_data;
                REG_CONSTRUCTION_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                default:               ;
            endcase
        end
    end

    // order tests, modulus and block-folded indexes
    always_comb
    begin
        q1   = order_reg - ORD_W'(1);
        half = order_reg[ORD_W-1:1];
        q2   = half - IDX_W'(1);
        n_ok = (order_reg != '0)
            && (32'(order_reg) <= 32'(MAX_ORDER))
            && ({1'b0, row_reg} < order_reg)
            && ({1'b0, col_reg} < order_reg);
        unique case (mode_reg)
            MODE_SYLVESTER: ord_ok = ((order_reg & q1) == '0);
            MODE_PALEY1:    ord_ok = (q1[1:0] == 2'd3);
            MODE_PALEY2:    ord_ok = !order_reg[0] && (q2[1:0] == 2'd1);
            default:        ord_ok = 1'b0;
        endcase
        rb = (mode_reg == MODE_PALEY2) && (row_reg >= half);
        cb = (mode_reg == MODE_PALEY2) && (col_reg >= half);
        rr = rb ? row_reg - half : row_reg;
        cc = cb ? col_reg - half : col_reg;
    end

    // entry class and Euler base (rr - cc) mod q
    always_comb
    begin
        eq   = (rr_reg == cc_reg);
        rz   = (rr_reg == '0);
        cz   = (cc_reg == '0);
        inv  = 1'b0;
        euler = 1'b0;
        direct_neg = 1'b0;
        priority if (syl_mode_reg)
        begin
            direct_neg = syl_neg_reg;
        end
        else if (pal2_mode_reg)
        begin
            inv = rb_reg & cb_reg;
            priority if (eq)
                direct_neg = rb_reg | cb_reg;
            else if (rz || cz)
                direct_neg = rb_reg & cb_reg;
            else
                euler = 1'b1;
        end
        else
        begin
            priority if (rz || eq)
                direct_neg = 1'b0;
            else if (cz)
                direct_neg = 1'b1;
            else
                euler = 1'b1;
        end
        diff  = {1'b0, QW'(rr_reg)} - {1'b0, QW'(cc_reg)};
        a_mod = diff[QW] ? diff[QW-1:0] + q_reg : diff[QW-1:0];
    end

    // multiplier pair: res*base and base*base share the bit counter
    assign acc_r_next = mm_step(acc_r_reg, res_reg[cnt_reg], base_reg, q_reg);
    assign acc_b_next = mm_step(acc_b_reg, base_reg[cnt_reg], base_reg, q_reg);
    assign nonres     = (res_reg != QW'(1));

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= row_index;
            col_reg <= col_index;
        end
        if (cmd.prep)
        begin
            ok_reg        <= n_ok & ord_ok;
            q_reg         <= (mode_reg == MODE_PALEY2) ? QW'(q2) : QW'(q1);
            rr_reg        <= rr;
            cc_reg        <= cc;
            rb_reg        <= rb;
            cb_reg        <= cb;
            syl_neg_reg   <= ^(row_reg & col_reg);
            syl_mode_reg  <= (mode_reg == MODE_SYLVESTER);
            pal2_mode_reg <= (mode_reg == MODE_PALEY2);
        end
        if (cmd.classify)
        begin
            direct_neg_reg <= direct_neg;
            inv_reg        <= inv;
            euler_reg      <= ok_reg & euler;
            exp_reg        <= q_reg >> 1;
            res_reg        <= (q_reg == QW'(1)) ? '0 : QW'(1);
            base_reg       <= a_mod;
        end
        if (cmd.mul_start)
        begin
            acc_r_reg <= '0;
            acc_b_reg <= '0;
            cnt_reg   <= CNT_TOP;
        end
        if (cmd.mul_step)
        begin
            acc_r_reg <= acc_r_next;
            acc_b_reg <= acc_b_next;
            cnt_reg   <= cnt_reg - CW'(1);
            // last bit: store the square, the product if exp_reg[0], and shift exp_reg
            if (cnt_reg == '0)
            begin
                base_reg <= acc_b_next;
                if (exp_reg[0])
                    res_reg <= acc_r_next;
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.out_load)
        begin
            entry_negative_reg <= ok_reg & (euler_reg ? (nonres ^ inv_reg) : direct_neg_reg);
            invalid_reg        <= !ok_reg;
        end
    end

    assign status.need_euler = euler_reg;
    assign status.exp_zero   = (exp_reg == '0);
    assign status.cnt_zero   = (cnt_reg == '0);

    assign entry_negative = entry_negative_reg;
    assign invalid        = invalid_reg;

endmodule

@@ rtl/hadamard_matrix_entry_generator.sv @@
// hadamard_matrix_entry_generator: top level joining the controller and the datapath
//
//   channel  handshake              word
//   -------  ---------------------  -----------------------------------
//   in       in_valid / in_stall    row_index, col_index
//   out      out_valid / out_stall  entry_negative, invalid
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a word is taken in S_IDLE and passes S_PREP, S_CLASS and S_CHECK before S_DONE loads
// its result word; for a Paley core entry S_MUL and S_CHECK first raise the Euler base
// to the power (q - 1) / 2 by square and multiply; none runs for Sylvester entries,
// special Paley entries and invalid requests; the bit-serial multiplier pair takes
// one bit per cycle over QW = clog2(MAX_ORDER) bits; no new word until the result loads
// rst_n clears the state machine and the output valid flag, order 4, Sylvester mode
// a new word is taken while a finished result waits under out_stall
`timescale 1ns / 1ps

module hadamard_matrix_entry_generator
    import hmeg_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [IDX_W-1:0]     row_index,
    input  logic [IDX_W-1:0]     col_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 entry_negative,
    output logic                 invalid,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORD_W-1:0]     cfg_data
);

    hmeg_cmd_t    cmd;
    hmeg_status_t status;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // sequencer
    hmeg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and configuration
    hmeg_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_valid & cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .row_index      (row_index),
        .col_index      (col_index),
        .cmd            (cmd),
        .status         (status),
        .entry_negative (entry_negative),
        .invalid        (invalid)
    );

endmodule

@@ tb/hmeg_sign_checker.sv @@
// hmeg_sign_checker: watches the channels, predicts each entry sign and compares
`timescale 1ns / 1ps

module hmeg_sign_checker
    import hmeg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [IDX_W-1:0]     row_index,
    input  logic [IDX_W-1:0]     col_index,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 entry_negative,
    input  logic                 invalid,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ORD_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding
);

    typedef struct packed {
        logic negative;
        logic unusable;
    } entry_sign_t;

    // shadow copy of the configuration registers
    logic [ORD_W-1:0]  order_q;
    logic [MODE_W-1:0] mode_q;

    // expected words, oldest first
    entry_sign_t pending_signs[$];

    // euler's criterion by square and multiply; anything other than 1 is a non-residue
    function automatic logic is_nonresidue(int unsigned a, int unsigned q);
        int unsigned expo;
        int unsigned acc;
        int unsigned base;
        expo = (q - 1) / 2;
        acc  = 1 % q;
        base = a % q;
        while (expo != 0) begin
            if ((expo & 1) != 0)
                acc = (acc * base) % q;
            base = (base * base) % q;
            expo = expo >> 1;
        end
        return acc != 1;
    endfunction

    // sign of one matrix entry under the current order and mode
    function automatic entry_sign_t predict_sign(int unsigned r, int unsigned c);
        int unsigned n;
        int unsigned q;
        int unsigned h;
        int unsigned rr;
        int unsigned cc;
        logic        ok;
        logic        neg;
        logic        rb;
        logic        cb;
        logic        cneg;
        entry_sign_t sign;
        n   = order_q;
        ok  = (n != 0) && (n <= MAX_ORDER_DEF) && (r < n) && (c < n);
        neg = 1'b0;
        if (ok) begin
            case (mode_q)
                MODE_SYLVESTER:
                begin
                    if ((n & (n - 1)) != 0)
                        ok = 1'b0;
                    else
                        neg = ^(r & c);
                end
                MODE_PALEY1:
                begin
                    q = n - 1;
                    if ((q % 4) != 3)
                        ok = 1'b0;
                    else if (r == 0 || r == c)
                        neg = 1'b0;
                    else if (c == 0)
                        neg = 1'b1;
                    else
                        neg = is_nonresidue(r + q - c, q);
                end
                MODE_PALEY2:
                begin
                    q = n / 2 - 1;
                    if ((n % 2) != 0 || (q % 4) != 1) begin
                        ok = 1'b0;
                    end
                    else begin
                        // quadrant of the block form, then the core index inside it
                        h  = q + 1;
                        rb = r >= h;
                        cb = c >= h;
                        rr = rb ? r - h : r;
                        cc = cb ? c - h : c;
                        if (rr == cc) begin
                            neg = rb || cb;
                        end
                        else begin
                            cneg = 1'b0;
                            if (rr != 0 && cc != 0)
                                cneg = is_nonresidue(rr + q - cc, q);
                            neg = cneg ^ (rb && cb);
                        end
                    end
                end
                default:
                    ok = 1'b0;
            endcase
        end
        sign.negative = ok && neg;
        sign.unusable = !ok;
        return sign;
    endfunction

    // track register writes, queue predictions and compare each result word
    always @(posedge clk or negedge rst_n)
    begin : track_words
        entry_sign_t want;
        int          errs;
        int          delta;
        if (!rst_n) begin
            order_q     <= ORDER_RESET;
            mode_q      <= MODE_RESET;
            fail_count  <= 0;
            outstanding <= 0;
            pending_signs.delete();
        end
        else begin
            errs  = 0;
            delta = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MATRIX_ORDER:      order_q <= cfg_data;
                    REG_CONSTRUCTION_MODE: mode_q  <= cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            // check the result first so a word accepted this edge cannot match it
            if (out_valid && !out_stall) begin
                delta = delta - 1;
                if (pending_signs.size() == 0) begin
                    $error("result word with nothing expected: entry_negative %0b invalid %0b",
                           entry_negative, invalid);
                    errs++;
                end
                else begin
                    want = pending_signs.pop_front();
                    if (entry_negative !== want.negative) begin
                        $error("entry_negative: expected %0b, got %0b",
                               want.negative, entry_negative);
                        errs++;
                    end
                    if (invalid !== want.unusable) begin
                        $error("invalid: expected %0b, got %0b", want.unusable, invalid);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall) begin
                pending_signs.push_back(predict_sign(row_index, col_index));
                delta = delta + 1;
            end
            fail_count  <= fail_count + errs;
            outstanding <= outstanding + delta;
        end
    end

endmodule

@@ tb/hadamard_matrix_entry_generator_tb.sv @@
// hadamard_matrix_entry_generator_tb: stimulus, flow control and verdict for the entry generator
`timescale 1ns / 1ps

module hadamard_matrix_entry_generator_tb;
    import hmeg_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    // register settings visited after the reset setting and directed words
    localparam int PLAN_LEN = 21;
    localparam int PLAN_ORDER [PLAN_LEN] = '{
        1024, 1, 8, 12,
        4, 12, 20, 1024, 10,
        12, 28, 20, 1020, 11, 14,
        0, 2047, 1025, 4, 8,
        28
    };
    localparam logic [MODE_W-1:0] PLAN_MODE [PLAN_LEN] = '{
        MODE_SYLVESTER, MODE_SYLVESTER, MODE_SYLVESTER, MODE_SYLVESTER,
        MODE_PALEY1, MODE_PALEY1, MODE_PALEY1, MODE_PALEY1, MODE_PALEY1,
        MODE_PALEY2, MODE_PALEY2, MODE_PALEY2, MODE_PALEY2, MODE_PALEY2, MODE_PALEY2,
        MODE_SYLVESTER, MODE_PALEY1, MODE_SYLVESTER, MODE_UNUSED, MODE_UNUSED,
        MODE_PALEY2
    };
    localparam int PLAN_WORDS [PLAN_LEN] = '{
        80, 15, 30, 15,
        30, 50, 20, 40, 15,
        40, 60, 25, 30, 10, 10,
        10, 10, 10, 10, 10,
        20
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [IDX_W-1:0]     row_index;
    logic [IDX_W-1:0]     col_index;
    logic                 out_valid;
    logic                 out_stall;
    logic                 entry_negative;
    logic                 invalid;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ORD_W-1:0]     cfg_data;

    int fail_count;
    int outstanding;
    int result_count = 0;
    int cycle_count = 0;

    hadamard_matrix_entry_generator i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .row_index      (row_index),
        .col_index      (col_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_negative (entry_negative),
        .invalid        (invalid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    hmeg_sign_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .row_index      (row_index),
        .col_index      (col_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_negative (entry_negative),
        .invalid        (invalid),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // clock
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hadamard_matrix_entry_generator_tb: errors");
            $finish;
        end
    end

    // count accepted result words to time the long holds
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            result_count <= result_count + 1;
    end

    // receiver: shifting stall patterns, plus two long holds while words keep coming
    initial
    begin : receiver
        int pattern;
        int pattern_left;
        int hold_left;
        int holds_done;
        pattern      = 0;
        pattern_left = 0;
        hold_left    = 0;
        holds_done   = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 80);
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if ((holds_done == 0 && result_count >= 60) ||
                     (holds_done == 1 && result_count >= 300)) begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else begin
                case (pattern)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // offer one word and hold it until accepted
    task automatic push_word(input int unsigned r, input int unsigned c);
        in_valid  <= 1'b1;
        row_index <= r[IDX_W-1:0];
        col_index <= c[IDX_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers, block idle
    task automatic write_config(input int unsigned order, input logic [MODE_W-1:0] mode);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MATRIX_ORDER;
        cfg_data  <= order[ORD_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_CONSTRUCTION_MODE;
        cfg_data  <= {{(ORD_W-MODE_W){1'b0}}, mode};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random words in bursts, mostly inside the order, some anywhere, some on the edge
    task automatic feed_random(input int unsigned order, input int count);
        int          burst;
        int          gap;
        int unsigned hi;
        int unsigned r;
        int unsigned c;
        int unsigned sel;
        burst = 0;
        hi    = (order >= 1 && order <= 1024) ? order - 1 : 1023;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 24);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if ($urandom_range(0, 59) == 0)
                drain_results();
            sel = $urandom_range(0, 19);
            if (sel < 17) begin
                r = $urandom_range(0, hi);
                c = $urandom_range(0, hi);
            end
            else if (sel < 19) begin
                r = $urandom_range(0, 1023);
                c = $urandom_range(0, 1023);
            end
            else begin
                r = (order <= 1023) ? order : 1023;
                c = $urandom_range(0, hi);
                if ($urandom_range(0, 1) == 1) begin
                    sel = r;
                    r   = c;
                    c   = sel;
                end
            end
            push_word(r, c);
            burst--;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        row_index    <= '0;
        col_index    <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_MATRIX_ORDER;
        cfg_data     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: order 4 sylvester, corners and out of range
        push_word(0, 0);
        push_word(3, 3);
        push_word(3, 1);
        push_word(4, 0);
        push_word(0, 4);
        push_word(1023, 1023);
        feed_random(ORDER_RESET, 20);
        drain_results();

        // largest sylvester order at the index extremes
        write_config(1024, MODE_SYLVESTER);
        push_word(1023, 1023);
        push_word(1023, 0);
        push_word(682, 341);
        push_word(0, 1023);
        drain_results();

        // paley i, q = 11: first row, first column, diagonal, core entries
        write_config(12, MODE_PALEY1);
        push_word(0, 5);
        push_word(5, 0);
        push_word(5, 5);
        push_word(3, 7);
        push_word(11, 1);
        drain_results();

        // paley ii, q = 5: quadrant diagonals and core entries of the two diagonal blocks
        write_config(12, MODE_PALEY2);
        push_word(6, 6);
        push_word(6, 0);
        push_word(0, 6);
        push_word(7, 8);
        push_word(8, 7);
        push_word(1, 2);
        push_word(11, 11);
        drain_results();

        // random words under each setting
        for (int p = 0; p < PLAN_LEN; p++) begin
            write_config(PLAN_ORDER[p], PLAN_MODE[p]);
            feed_random(PLAN_ORDER[p], PLAN_WORDS[p]);
            drain_results();
        end

        if (fail_count == 0)
            $display("hadamard_matrix_entry_generator_tb: clean");
        else
            $display("hadamard_matrix_entry_generator_tb: errors");
        $finish;
    end

endmodule
